[design/gif_lzw_decoder_unit_defines.svh]
// Assertion macros used by the decoder unit.
`ifndef GIF_LZW_DECODER_UNIT_DEFINES_SVH
`define GIF_LZW_DECODER_UNIT_DEFINES_SVH
// Implication checked on every clock edge, disabled during reset.
`define GLD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked on every clock edge, disabled during reset.
`define GLD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[design/gld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Payload types, request, status and config codes and decode phases.
// ----------------------------------------------------------------------------
package gld_pkg;
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} gld_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] pixel;
	} gld_out_t;

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_PULL = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [2:0] ST_TAKEN = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_PIXEL = 3'd2;
	localparam logic [2:0] ST_NEED = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_NORMAL = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam logic [1:0] CFG_ROOT = 2'd0;
	localparam logic [1:0] CFG_COLOR = 2'd1;
	localparam logic [1:0] CFG_LIMIT = 2'd2;
endpackage

[design/gif_lzw_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder unit
// Byte-fed, pixel-pulled LZW raster decoder with 12-bit code table.
// ----------------------------------------------------------------------------
// Each request beat gives one response beat. Byte offers and starts pass
// S_OUT. A pull that pops the string stack passes S_POP and then S_OUT. A pull
// that decodes a code walks the prefix chain one table entry per S_WALKRD and
// S_WALK pair, through a single read port of the prefix and suffix memories,
// and reads any clear codes met along the way in S_DECODE. The response waits
// in an output register, and the next request is taken only once it has been
// delivered.
module gif_lzw_decoder_unit #(
	parameter int MAX_CODE_BITS = 12,
	parameter int TABLE_DEPTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  gld_pkg::gld_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output gld_pkg::gld_out_t out_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import gld_pkg::*;
	`include "gif_lzw_decoder_unit_defines.svh"

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = AW + 1;
	localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
	localparam logic [NW-1:0] STACK_MAX = NW'(TABLE_DEPTH - 1);
	localparam logic [3:0] MAXW = 4'(MAX_CODE_BITS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_WALKRD = 3'd3;
	localparam logic [2:0] S_POP = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q;
	logic [3:0] root_q, color_q;
	logic [31:0] limit_q;
	logic [23:0] buf_q;
	logic [4:0] cnt_q;
	logic [3:0] cw_q;
	logic [NW-1:0] nfc_q;
	logic [11:0] prev_q, newprev_q;
	logic [7:0] first_q;
	logic [NW-1:0] sp_q;
	logic [31:0] pix_q;
	logic [1:0] phase_q;
	logic [11:0] cur_q;
	gld_out_t out_q;
	logic out_valid_q;

	logic [11:0] prefix_mem [TABLE_DEPTH];
	logic [7:0] suffix_mem [TABLE_DEPTH];
	logic [7:0] stack_mem [TABLE_DEPTH];
	logic [11:0] pre_rd_q;
	logic [7:0] suf_rd_q, stk_rd_q;

	logic [3:0] rs;
	logic [12:0] clr;
	logic [7:0] msk;
	logic [11:0] code;
	logic walk_go;
	logic [7:0] kval;

	always_comb begin
		rs = root_q;
		if (rs < 4'd2) rs = 4'd2;
		if (rs > 4'd8) rs = 4'd8;
		clr = 13'd1 << rs;
		if (color_q == 4'd0) msk = 8'h01;
		else if (color_q >= 4'd8) msk = 8'hFF;
		else msk = 8'((9'd1 << color_q) - 9'd1);
		code = 12'(buf_q & ((24'd1 << cw_q) - 24'd1));
		walk_go = ({1'b0, cur_q} >= clr + 13'd2) && (13'(cur_q) < 13'(nfc_q))
			&& (13'(cur_q) < 13'(DEPTH_N)) && (sp_q < STACK_MAX);
		kval = cur_q[7:0] & msk;
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (state_q == S_WALK && walk_go) begin
			stack_mem[sp_q[AW-1:0]] <= suf_rd_q;
		end else if (state_q == S_DECODE && cnt_q >= 5'(cw_q) && 13'(code) != clr
				&& 13'(code) != clr + 13'd1 && phase_q != PH_FIRST
				&& 13'(code) >= 13'(nfc_q)) begin
			stack_mem[sp_q[AW-1:0]] <= first_q;
		end
		if (state_q == S_WALK && !walk_go && nfc_q < DEPTH_N) begin
			prefix_mem[nfc_q[AW-1:0]] <= prev_q;
			suffix_mem[nfc_q[AW-1:0]] <= kval;
		end
		pre_rd_q <= prefix_mem[cur_q[AW-1:0]];
		suf_rd_q <= suffix_mem[cur_q[AW-1:0]];
		stk_rd_q <= stack_mem[AW'(sp_q - NW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			root_q <= 4'd8;
			color_q <= 4'd8;
			limit_q <= 32'd4294836225;
			buf_q <= '0;
			cnt_q <= '0;
			cw_q <= 4'd9;
			nfc_q <= NW'(258);
			prev_q <= '0;
			newprev_q <= '0;
			first_q <= '0;
			sp_q <= '0;
			pix_q <= '0;
			phase_q <= PH_FIRST;
			cur_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROOT: root_q <= cfg_data[3:0];
					CFG_COLOR: color_q <= cfg_data[3:0];
					CFG_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						out_q.pixel <= '0;
						state_q <= S_OUT;
						case (in_data.req_type)
							REQ_BYTE: begin
								if (phase_q == PH_DONE || cnt_q > 5'd16) begin
									out_q.status <= ST_REFUSED;
								end else begin
									buf_q <= buf_q | (24'(in_data.data_byte) << cnt_q);
									cnt_q <= cnt_q + 5'd8;
									out_q.status <= ST_TAKEN;
								end
							end
							REQ_PULL: begin
								if (phase_q == PH_DONE) begin
									out_q.status <= ST_DONE;
								end else if (pix_q >= limit_q) begin
									phase_q <= PH_DONE;
									out_q.status <= ST_DONE;
								end else if (sp_q != '0) begin
									state_q <= S_POP;
								end else begin
									state_q <= S_DECODE;
								end
							end
							REQ_START: begin
								buf_q <= '0;
								cnt_q <= '0;
								cw_q <= rs + 4'd1;
								nfc_q <= NW'(clr + 13'd2);
								prev_q <= '0;
								first_q <= '0;
								sp_q <= '0;
								pix_q <= '0;
								phase_q <= PH_FIRST;
								out_q.status <= ST_TAKEN;
							end
							default: out_q.status <= ST_REFUSED;
						endcase
					end
				end
				S_POP: begin
					sp_q <= sp_q - NW'(1);
					pix_q <= pix_q + 32'd1;
					out_q.status <= ST_PIXEL;
					out_q.pixel <= stk_rd_q;
					state_q <= S_OUT;
				end
				S_DECODE: begin
					if (cnt_q < 5'(cw_q)) begin
						out_q.status <= ST_NEED;
						state_q <= S_OUT;
					end else begin
						buf_q <= buf_q >> cw_q;
						cnt_q <= cnt_q - 5'(cw_q);
						if (13'(code) == clr) begin
							cw_q <= rs + 4'd1;
							nfc_q <= NW'(clr + 13'd2);
							phase_q <= PH_FIRST;
						end else if (13'(code) == clr + 13'd1) begin
							phase_q <= PH_DONE;
							out_q.status <= ST_DONE;
							state_q <= S_OUT;
						end else if (phase_q == PH_FIRST) begin
							prev_q <= 12'(code[7:0] & msk);
							first_q <= code[7:0] & msk;
							phase_q <= PH_NORMAL;
							pix_q <= pix_q + 32'd1;
							out_q.status <= ST_PIXEL;
							out_q.pixel <= code[7:0] & msk;
							state_q <= S_OUT;
						end else if (13'(code) < 13'(nfc_q)) begin
							cur_q <= code;
							newprev_q <= code;
							state_q <= S_WALKRD;
						end else begin
							sp_q <= sp_q + NW'(1);
							cur_q <= prev_q;
							newprev_q <= (nfc_q < DEPTH_N) ? 12'(nfc_q) : prev_q;
							state_q <= S_WALKRD;
						end
					end
				end
				S_WALKRD: state_q <= S_WALK;
				S_WALK: begin
					if (walk_go) begin
						sp_q <= sp_q + NW'(1);
						cur_q <= pre_rd_q;
						state_q <= S_WALKRD;
					end else begin
						if (nfc_q < DEPTH_N) begin
							nfc_q <= nfc_q + NW'(1);
							if ((nfc_q + NW'(1)) >= (NW'(1) << cw_q) && cw_q < MAXW)
								cw_q <= cw_q + 4'd1;
						end
						prev_q <= newprev_q;
						first_q <= kval;
						pix_q <= pix_q + 32'd1;
						out_q.status <= ST_PIXEL;
						out_q.pixel <= kval;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GLD_ASSERT_IMP(a_ready_idle, in_ready, state_q == S_IDLE)
	`GLD_ASSERT_NEXT(a_one_resp, in_valid && in_ready, !out_valid_q)
	`GLD_ASSERT_IMP(a_cw_range, 1'b1, cw_q <= MAXW)
	`GLD_ASSERT_IMP(a_stack_bound, 1'b1, sp_q <= STACK_MAX)
	`GLD_ASSERT_NEXT(a_out_from_s, state_q == S_OUT, out_valid_q)
endmodule
